@@ sv/cfno_pkg.sv @@
// ============================================================================
// cfno_pkg: shared types and constants for the class-filtered neighbor offset
// Holds the beat formats of both channels, the job record passed from the
// front end to the back end, field widths and register indexes.
// ============================================================================
package cfno_pkg;

    localparam int MAX_NEIGHBORS = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam int COORD_W = 32;
    localparam int CLASS_W = 8;
    localparam int CNT_W   = $clog2(MAX_NEIGHBORS + 1);
    localparam int SUM_W   = COORD_W + $clog2(MAX_NEIGHBORS);
    localparam int MEAN_W  = COORD_W + 1;
    localparam int DIFF_W  = COORD_W + 2;
    localparam int FEAT_W  = DIFF_W;
    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int RAD_W   = SQ_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int STEP_W  = $clog2(SUM_W + MAG_W + ROOT_W + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CLASS_W;

    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTEXT_CLASS = 1'd1;

    localparam logic MODE_VERTICAL   = 1'b0;
    localparam logic MODE_HORIZONTAL = 1'b1;

    localparam logic KIND_QUERY    = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic [CLASS_W-1:0]        point_class;
        logic                      last_item;
    } in_beat_t;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_value;
        logic                     is_nan;
    } out_beat_t;

    typedef struct packed {
        logic signed [SUM_W-1:0]   sum_x;
        logic signed [SUM_W-1:0]   sum_y;
        logic signed [SUM_W-1:0]   sum_z;
        logic [CNT_W-1:0]          match_count;
        logic signed [COORD_W-1:0] query_x;
        logic signed [COORD_W-1:0] query_y;
        logic signed [COORD_W-1:0] query_z;
        logic                      feature_mode;
    } job_t;

endpackage

@@ sv/cfno_front.sv @@
// ============================================================================
// cfno_front: item intake and class-filtered accumulation
// Latches query points, sums matching neighbor coordinates and hands a
// finished neighborhood to the job queue on its last beat.
// ============================================================================
module cfno_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cfno_pkg::in_beat_t            in_data,
    input  logic                          feature_mode,
    input  logic [cfno_pkg::CLASS_W-1:0]  context_class,
    input  logic                          q_full,
    output logic                          push,
    output cfno_pkg::job_t                job
);
    import cfno_pkg::*;

    logic signed [SUM_W-1:0]   sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]   sum_x_next, sum_y_next, sum_z_next;
    logic [CNT_W-1:0]          match_count_reg, match_count_next;
    logic [CNT_W-1:0]          nbr_count_reg, nbr_count_next;
    logic signed [COORD_W-1:0] query_x_reg, query_y_reg, query_z_reg;
    logic signed [COORD_W-1:0] query_x_next, query_y_next, query_z_next;
    logic                      accept;
    logic                      is_query;
    logic                      take;
    logic                      hit;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    always_comb
    begin
        is_query = (in_data.kind == KIND_QUERY);
        take     = !is_query && (nbr_count_reg < CNT_W'(MAX_NEIGHBORS));
        hit      = take && (in_data.point_class == context_class);

        sum_x_next = (is_query ? SUM_W'(0) : sum_x_reg)
                   + (hit ? SUM_W'(in_data.coord_x) : SUM_W'(0));
        sum_y_next = (is_query ? SUM_W'(0) : sum_y_reg)
                   + (hit ? SUM_W'(in_data.coord_y) : SUM_W'(0));
        sum_z_next = (is_query ? SUM_W'(0) : sum_z_reg)
                   + (hit ? SUM_W'(in_data.coord_z) : SUM_W'(0));

        match_count_next = (is_query ? CNT_W'(0) : match_count_reg) + CNT_W'(hit);
        nbr_count_next   = (is_query ? CNT_W'(0) : nbr_count_reg) + CNT_W'(take);

        query_x_next = is_query ? in_data.coord_x : query_x_reg;
        query_y_next = is_query ? in_data.coord_y : query_y_reg;
        query_z_next = is_query ? in_data.coord_z : query_z_reg;

        push             = accept & in_data.last_item;
        job.sum_x        = sum_x_next;
        job.sum_y        = sum_y_next;
        job.sum_z        = sum_z_next;
        job.match_count  = match_count_next;
        job.query_x      = query_x_next;
        job.query_y      = query_y_next;
        job.query_z      = query_z_next;
        job.feature_mode = feature_mode;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            sum_z_reg       <= '0;
            match_count_reg <= '0;
            nbr_count_reg   <= '0;
            query_x_reg     <= '0;
            query_y_reg     <= '0;
            query_z_reg     <= '0;
        end
        else if (accept)
        begin
            query_x_reg <= query_x_next;
            query_y_reg <= query_y_next;
            query_z_reg <= query_z_next;
            if (in_data.last_item)
            begin
                sum_x_reg       <= '0;
                sum_y_reg       <= '0;
                sum_z_reg       <= '0;
                match_count_reg <= '0;
                nbr_count_reg   <= '0;
            end
            else
            begin
                sum_x_reg       <= sum_x_next;
                sum_y_reg       <= sum_y_next;
                sum_z_reg       <= sum_z_next;
                match_count_reg <= match_count_next;
                nbr_count_reg   <= nbr_count_next;
            end
        end
    end

endmodule

@@ sv/cfno_queue.sv @@
// ============================================================================
// cfno_queue: job queue between front end and back end
// A short first-in first-out buffer of finished neighborhood records.
// ============================================================================
module cfno_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cfno_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output cfno_pkg::job_t pop_data,
    output logic           empty
);
    import cfno_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                            : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

@@ sv/cfno_back.sv @@
// ============================================================================
// cfno_back: mean, offset and distance evaluation
// Takes one job at a time: bit-serial mean division on all three axes, then
// either the vertical offset or the shift-add squares and a bit-pair square
// root for the horizontal distance, ending in a registered result beat.
// ============================================================================
module cfno_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  cfno_pkg::job_t      job,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output cfno_pkg::out_beat_t out_data
);
    import cfno_pkg::*;

    localparam int NUM_AXES   = 3;
    localparam int NUM_PLANAR = 2;
    localparam int AXIS_X     = 0;
    localparam int AXIS_Y     = 1;
    localparam int AXIS_Z     = 2;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_DIFF = 8'b0000_0100,
        ST_LOAD = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_RAD  = 8'b0010_0000,
        ST_ROOT = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } state_t;

    state_t                    state_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      mode_reg;
    logic                      nan_reg;
    logic [CNT_W-1:0]          div_n_reg;
    logic [SUM_W-1:0]          quo_reg   [NUM_AXES];
    logic [CNT_W-1:0]          rem_reg   [NUM_AXES];
    logic                      neg_reg   [NUM_AXES];
    logic signed [COORD_W-1:0] query_reg [NUM_AXES];
    logic signed [DIFF_W-1:0]  diff_reg  [NUM_AXES];
    logic [SQ_W-1:0]           mcand_reg [NUM_PLANAR];
    logic [SQ_W-1:0]           acc_reg   [NUM_PLANAR];
    logic [MAG_W-1:0]          mplier_reg[NUM_PLANAR];
    logic [RAD_W-1:0]          rad_reg;
    logic [ROOT_W:0]           rrem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic                      out_valid_reg;
    out_beat_t                 out_data_reg;

    logic signed [SUM_W-1:0]   job_sum  [NUM_AXES];
    logic signed [COORD_W-1:0] job_query[NUM_AXES];
    logic [SUM_W-1:0]          job_mag  [NUM_AXES];
    logic [CNT_W:0]            r_sh     [NUM_AXES];
    logic [CNT_W:0]            r_sub    [NUM_AXES];
    logic                      div_ge   [NUM_AXES];
    logic [CNT_W-1:0]          rem_step [NUM_AXES];
    logic [SUM_W-1:0]          quo_step [NUM_AXES];
    logic signed [DIFF_W-1:0]  q_ext    [NUM_AXES];
    logic signed [DIFF_W-1:0]  qry_ext  [NUM_AXES];
    logic signed [DIFF_W-1:0]  diff_val [NUM_AXES];
    logic [DIFF_W-1:0]         diff_abs [NUM_PLANAR];
    logic [ROOT_W+2:0]         root_rem_t;
    logic [ROOT_W+2:0]         root_trial;
    logic [ROOT_W+2:0]         root_sub;
    logic                      root_ge;
    logic                      out_free;
    logic                      job_nan;
    out_beat_t                 result;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign job_nan   = (job.match_count == '0);

    always_comb
    begin
        job_sum[AXIS_X]   = job.sum_x;
        job_sum[AXIS_Y]   = job.sum_y;
        job_sum[AXIS_Z]   = job.sum_z;
        job_query[AXIS_X] = job.query_x;
        job_query[AXIS_Y] = job.query_y;
        job_query[AXIS_Z] = job.query_z;

        for (int i = 0; i < NUM_AXES; i++)
        begin
            job_mag[i]  = job_sum[i][SUM_W-1] ? SUM_W'(-job_sum[i]) : SUM_W'(job_sum[i]);
            r_sh[i]     = {rem_reg[i], quo_reg[i][SUM_W-1]};
            r_sub[i]    = r_sh[i] - {1'b0, div_n_reg};
            div_ge[i]   = (r_sh[i] >= {1'b0, div_n_reg});
            rem_step[i] = div_ge[i] ? r_sub[i][CNT_W-1:0] : r_sh[i][CNT_W-1:0];
            quo_step[i] = {quo_reg[i][SUM_W-2:0], div_ge[i]};
            q_ext[i]    = signed'({1'b0, quo_reg[i][MEAN_W-1:0]});
            qry_ext[i]  = DIFF_W'(query_reg[i]);
            diff_val[i] = neg_reg[i] ? (qry_ext[i] + q_ext[i]) : (qry_ext[i] - q_ext[i]);
        end

        for (int j = 0; j < NUM_PLANAR; j++)
        begin
            diff_abs[j] = diff_reg[j][DIFF_W-1] ? DIFF_W'(-diff_reg[j])
                                                : DIFF_W'(diff_reg[j]);
        end

        root_rem_t = {rrem_reg, rad_reg[RAD_W-1 -: 2]};
        root_trial = {1'b0, root_reg, 2'b01};
        root_sub   = root_rem_t - root_trial;
        root_ge    = (root_rem_t >= root_trial);

        result.is_nan = nan_reg;
        if (nan_reg)
        begin
            result.feature_value = '0;
        end
        else if (mode_reg == MODE_HORIZONTAL)
        begin
            result.feature_value = signed'(FEAT_W'(root_reg));
        end
        else
        begin
            result.feature_value = diff_reg[AXIS_Z];
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    mode_reg  <= job.feature_mode;
                    nan_reg   <= job_nan;
                    div_n_reg <= job.match_count;
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        quo_reg[i]   <= job_mag[i];
                        rem_reg[i]   <= '0;
                        neg_reg[i]   <= job_sum[i][SUM_W-1];
                        query_reg[i] <= job_query[i];
                    end
                end
            end
            ST_DIV:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    quo_reg[i] <= quo_step[i];
                    rem_reg[i] <= rem_step[i];
                end
            end
            ST_DIFF:
            begin
                for (int i = 0; i < NUM_AXES; i++)
                begin
                    diff_reg[i] <= diff_val[i];
                end
            end
            ST_LOAD:
            begin
                for (int j = 0; j < NUM_PLANAR; j++)
                begin
                    mplier_reg[j] <= diff_abs[j][MAG_W-1:0];
                    mcand_reg[j]  <= SQ_W'(diff_abs[j][MAG_W-1:0]);
                    acc_reg[j]    <= '0;
                end
            end
            ST_MUL:
            begin
                for (int j = 0; j < NUM_PLANAR; j++)
                begin
                    acc_reg[j]    <= acc_reg[j] + (mplier_reg[j][0] ? mcand_reg[j] : '0);
                    mcand_reg[j]  <= {mcand_reg[j][SQ_W-2:0], 1'b0};
                    mplier_reg[j] <= {1'b0, mplier_reg[j][MAG_W-1:1]};
                end
            end
            ST_RAD:
            begin
                rad_reg  <= acc_reg[AXIS_X] + acc_reg[AXIS_Y];
                rrem_reg <= '0;
                root_reg <= '0;
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rrem_reg <= root_ge ? root_sub[ROOT_W:0] : root_rem_t[ROOT_W:0];
                root_reg <= {root_reg[ROOT_W-2:0], root_ge};
            end
            default:
            begin
            end
        endcase

        if ((state_reg == ST_DONE) && out_free)
        begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (!empty)
                    begin
                        state_reg <= job_nan ? ST_DONE : ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DIFF;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DIFF:
                begin
                    state_reg <= (mode_reg == MODE_HORIZONTAL) ? ST_LOAD : ST_DONE;
                end
                ST_LOAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (step_reg == STEP_W'(MAG_W - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_RAD;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_RAD:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (step_reg == STEP_W'(ROOT_W - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

@@ sv/class_filtered_neighbour_offset_top.sv @@
// ============================================================================
// class_filtered_neighbour_offset_top: class-filtered neighbor offset block
// Accumulates neighbors of the configured class around a query point and
// reports the vertical offset from, or horizontal distance to, their mean.
// ============================================================================
//
//   channel  direction  handshake            beat
//   in       input      in_valid / in_stall  in_beat_t   (query or neighbor)
//   out      output     out_valid/out_stall  out_beat_t  (one per neighborhood)
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// The front end takes one input beat per cycle while the two-entry job queue
// has room; in_stall is high only while that queue is full.
// The back end finds the means with a 38-step serial divider; a horizontal
// result adds a 33-step shift-add squarer and a 33-step square root, and an
// empty neighborhood skips all three.
// Reset clears the sums, counts, query point, configuration, queue and output.
// A stalled output holds its beat while the back end waits in its final state.
//
module class_filtered_neighbour_offset_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  cfno_pkg::in_beat_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cfno_pkg::out_beat_t               out_data,
    input  logic                              cfg_we,
    input  logic [cfno_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfno_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import cfno_pkg::*;

    logic               feature_mode_reg;
    logic [CLASS_W-1:0] context_class_reg;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    job_t               push_job;
    job_t               pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feature_mode_reg  <= MODE_VERTICAL;
            context_class_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FEATURE_MODE:  feature_mode_reg  <= cfg_wdata[0];
                REG_CONTEXT_CLASS: context_class_reg <= cfg_wdata[CLASS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    cfno_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .feature_mode  (feature_mode_reg),
        .context_class (context_class_reg),
        .q_full        (q_full),
        .push          (push),
        .job           (push_job)
    );

    cfno_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_job),
        .empty     (q_empty)
    );

    cfno_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .job       (pop_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ tb/sv/class_filtered_neighbour_offset_top_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// class_filtered_neighbour_offset_top_tb: self-checking bench for the offset
// Drives query and neighbor beats through the valid/stall input, predicts
// each vertical offset or horizontal distance, and compares every output beat
// in order. A directed table comes first, then random neighborhoods with
// random idling, a long output hold-off and reconfiguration between phases.
// ============================================================================
module class_filtered_neighbour_offset_top_tb;

    import cfno_pkg::*;

    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 600;
    localparam int HOLD_OFF     = 400;

    typedef struct {
        bit        is_cfg;
        logic      mode;
        logic [7:0] cls;
        in_beat_t  beat;
        bit        typed;
        out_beat_t want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_beat_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    stim_row_t stim_table[$];
    out_beat_t feature_due[$];

    logic       cur_mode;
    logic [7:0] cur_class;
    longint     acc_x, acc_y, acc_z;
    longint     qry_x, qry_y, qry_z;
    int         hits;
    int         seen;

    bit quiet;
    int hold_cycles;
    int errors;
    int beats_driven;
    int random_items;
    int results_checked;
    int nan_checked;
    int phase_no;

    class_filtered_neighbour_offset_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit predict_feature(input in_beat_t b, output out_beat_t r);
        longint      n;
        longint      dx;
        longint      dy;
        logic [67:0] ux;
        logic [67:0] uy;
        logic [67:0] rad;
        logic [67:0] tt;
        logic [33:0] root;
        logic [33:0] trial;
        r = '0;
        if (b.kind == KIND_QUERY)
        begin
            qry_x = longint'(b.coord_x);
            qry_y = longint'(b.coord_y);
            qry_z = longint'(b.coord_z);
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            hits  = 0;
            seen  = 0;
        end
        else if (seen < MAX_NEIGHBORS)
        begin
            seen++;
            if (b.point_class == cur_class)
            begin
                acc_x += longint'(b.coord_x);
                acc_y += longint'(b.coord_y);
                acc_z += longint'(b.coord_z);
                hits++;
            end
        end
        if (!b.last_item)
            return 1'b0;
        if (hits == 0)
            r.is_nan = 1'b1;
        else
        begin
            n = longint'(hits);
            if (cur_mode == MODE_VERTICAL)
                r.feature_value = FEAT_W'(qry_z - acc_z / n);
            else
            begin
                dx = qry_x - acc_x / n;
                dy = qry_y - acc_y / n;
                if (dx < 0)
                    dx = -dx;
                if (dy < 0)
                    dy = -dy;
                ux = 68'(dx);
                uy = 68'(dy);
                rad = ux * ux + uy * uy;
                root = '0;
                for (int k = 33; k >= 0; k--)
                begin
                    trial = root | (34'd1 << k);
                    tt = 68'(trial);
                    if (tt * tt <= rad)
                        root = trial;
                end
                r.feature_value = root;
            end
        end
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        hits  = 0;
        seen  = 0;
        return 1'b1;
    endfunction

    function automatic void add_beat(input logic kind, input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [7:0] cls,
                                     input logic last);
        stim_row_t row;
        row = '{default: '0};
        row.beat.kind        = kind;
        row.beat.coord_x     = x;
        row.beat.coord_y     = y;
        row.beat.coord_z     = z;
        row.beat.point_class = cls;
        row.beat.last_item   = last;
        stim_table.push_back(row);
    endfunction

    function automatic void want_result(input logic signed [FEAT_W-1:0] fv, input logic nan);
        stim_table[$].typed              = 1'b1;
        stim_table[$].want.feature_value = fv;
        stim_table[$].want.is_nan        = nan;
    endfunction

    function automatic void add_cfg(input logic mode, input logic [7:0] cls);
        stim_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.mode   = mode;
        row.cls    = cls;
        stim_table.push_back(row);
    endfunction

    function automatic logic [31:0] pick_coord(input logic [31:0] centre);
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return centre + 32'($urandom_range(65535)) - 32'd32768;
        endcase
    endfunction

    task automatic send_beat(input in_beat_t b, input bit typed, input out_beat_t want);
        out_beat_t r;
        while (!quiet && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_feature(b, r))
            feature_due.push_back(typed ? want : r);
        beats_driven++;
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (feature_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input logic mode, input logic [7:0] cls);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FEATURE_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(negedge clk);
        cfg_index <= REG_CONTEXT_CLASS;
        cfg_wdata <= cls;
        @(negedge clk);
        cfg_we    <= 1'b0;
        cur_mode  = mode;
        cur_class = cls;
    endtask

    task automatic run_hood(input int len_hint);
        in_beat_t    b;
        int          len;
        int          shape;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        shape = $urandom_range(19);
        if (len_hint >= 0)
            len = len_hint;
        else if (shape == 0)
            len = $urandom_range(62, 80);
        else
            len = $urandom_range(0, 10);
        if (shape == 1 && len == 0)
            len = 1;
        cx = $urandom;
        cy = $urandom;
        cz = $urandom;
        b = '0;
        if (shape == 2)
        begin
            b.kind = KIND_QUERY;
            b.coord_x = $urandom;
            b.coord_y = $urandom;
            b.coord_z = $urandom;
            b.point_class = 8'($urandom);
            send_beat(b, 1'b0, '0);
            random_items++;
        end
        if (shape != 1)
        begin
            b.kind        = KIND_QUERY;
            b.coord_x     = cx;
            b.coord_y     = cy;
            b.coord_z     = cz;
            b.point_class = 8'($urandom);
            b.last_item   = (len == 0);
            send_beat(b, 1'b0, '0);
            random_items++;
        end
        for (int i = 0; i < len; i++)
        begin
            b.kind        = KIND_NEIGHBOR;
            b.coord_x     = pick_coord(cx);
            b.coord_y     = pick_coord(cy);
            b.coord_z     = pick_coord(cz);
            b.point_class = ($urandom_range(99) < 70) ? cur_class : 8'($urandom);
            b.last_item   = (i == len - 1);
            send_beat(b, 1'b0, '0);
            if (i < MAX_NEIGHBORS)
                random_items++;
        end
    endtask

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= !quiet && ($urandom_range(99) < 9);
        end
    end

    initial
    begin
        out_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (feature_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected beat: value %0d nan %0b",
                                 out_data.feature_value, out_data.is_nan);
                end
                else
                begin
                    want = feature_due.pop_front();
                    results_checked++;
                    if (want.is_nan)
                        nan_checked++;
                    if (out_data.feature_value !== want.feature_value ||
                        out_data.is_nan !== want.is_nan)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected value %0d nan %0b, got value %0d nan %0b",
                                     want.feature_value, want.is_nan,
                                     out_data.feature_value, out_data.is_nan);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cur_mode  = MODE_VERTICAL;
        cur_class = 8'h00;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        qry_x = 0;
        qry_y = 0;
        qry_z = 0;
        hits  = 0;
        seen  = 0;
        quiet = 1'b0;
        hold_cycles     = 0;
        errors          = 0;
        beats_driven    = 0;
        random_items    = 0;
        results_checked = 0;
        nan_checked     = 0;
        phase_no        = 0;

        add_cfg(MODE_VERTICAL, 8'h00);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'h0000_0100, 8'h00, 1'b1);
        want_result(-34'sd256, 1'b0);
        add_beat(KIND_QUERY, 32'h0, 32'h0, 32'h7FFF_FFFF, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'h8000_0000, 8'h00, 1'b1);
        want_result(34'sd4294967295, 1'b0);
        add_beat(KIND_QUERY, 32'h0, 32'h0, 32'h8000_0000, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'h7FFF_FFFF, 8'h00, 1'b1);
        want_result(-34'sd4294967295, 1'b0);
        add_beat(KIND_QUERY, 32'h1234_5678, 32'h0, 32'h0, 8'hFF, 1'b1);
        want_result('0, 1'b1);
        add_beat(KIND_QUERY, 32'h0, 32'h0, 32'h0, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'h0000_0400, 8'h05, 1'b1);
        want_result('0, 1'b1);
        add_beat(KIND_QUERY, 32'h0, 32'h0, 32'h0, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'hFFFF_FFFE, 8'h00, 1'b1);
        want_result(34'sd1, 1'b0);
        add_cfg(MODE_HORIZONTAL, 8'hFF);
        add_beat(KIND_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 8'hFF, 1'b1);
        add_beat(KIND_QUERY, 32'h0, 32'h0, 32'h0, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0000_0300, 32'h0000_0400, 32'h0, 8'hFF, 1'b1);
        want_result(34'sd1280, 1'b0);
        add_beat(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h0, 32'h0, 32'h0, 8'hFE, 1'b1);
        want_result('0, 1'b1);
        add_beat(KIND_NEIGHBOR, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 8'hFF, 1'b1);
        add_cfg(MODE_VERTICAL, 8'h5A);
        add_beat(KIND_QUERY, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h00, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 8'h5A, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 8'hA5, 1'b0);
        add_beat(KIND_NEIGHBOR, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FF00, 8'h5A, 1'b1);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            if (stim_table[i].is_cfg)
            begin
                drain_results();
                write_config(stim_table[i].mode, stim_table[i].cls);
            end
            else
                send_beat(stim_table[i].beat, stim_table[i].typed, stim_table[i].want);
        end

        while (random_items < RANDOM_ITEMS)
        begin
            drain_results();
            case (phase_no % 4)
                0:       write_config(MODE_VERTICAL, 8'h00);
                1:       write_config(MODE_HORIZONTAL, 8'hFF);
                default: write_config(1'($urandom_range(1)), 8'($urandom));
            endcase
            quiet = (phase_no == 2);
            if (phase_no == 3)
            begin
                hold_cycles = HOLD_OFF;
                repeat (12) run_hood(1);
            end
            repeat (8) run_hood(-1);
            phase_no++;
        end
        quiet = 1'b0;
        drain_results();

        $display("tb: %0d beats driven over %0d phases, %0d results checked, %0d of them empty",
                 beats_driven, phase_no, results_checked, nan_checked);
        $display("tb: both modes, context classes 0, 255 and random, long output hold-off done");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
